[rtl/dtd_pkg.sv]
// shared types and constants for the double tap detector
// no dependencies; imported by dtd_within, double_tap_detector_top and tb_top
package dtd_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int RADIUS_W   = 12;
    localparam int LIMIT_W    = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ENABLE        = 3'd0,
        REG_TAP_RADIUS    = 3'd1,
        REG_TAP_MAX_DUR   = 3'd2,
        REG_DOUBLE_INTVL  = 3'd3,
        REG_SECOND_RADIUS = 3'd4
    } t_cfg_reg;

    localparam logic [RADIUS_W-1:0] TAP_RADIUS_RST    = 12'd10;
    localparam logic [LIMIT_W-1:0]  TAP_MAX_DUR_RST   = 16'd300;
    localparam logic [LIMIT_W-1:0]  DOUBLE_INTVL_RST  = 16'd300;
    localparam logic [RADIUS_W-1:0] SECOND_RADIUS_RST = 12'd20;

    typedef enum logic [2:0] {
        OUT_NONE   = 3'd0,
        OUT_FIRST  = 3'd1,
        OUT_DOUBLE = 3'd2,
        OUT_REJECT = 3'd3,
        OUT_FAILED = 3'd4
    } t_outcome;

    typedef enum logic [1:0] {
        TAP_NONE = 2'd0,
        TAP_OK   = 2'd1,
        TAP_FAIL = 2'd2
    } t_tap;

endpackage

[rtl/dtd_within.sv]
// squared distance check: (ax-bx)^2 + (ay-by)^2 <= radius^2
// depends on dtd_pkg
module dtd_within #(
    parameter int COORD_BITS = dtd_pkg::COORD_BITS_DEF
) (
    input  logic signed [COORD_BITS-1:0]        i_a_x,
    input  logic signed [COORD_BITS-1:0]        i_a_y,
    input  logic signed [COORD_BITS-1:0]        i_b_x,
    input  logic signed [COORD_BITS-1:0]        i_b_y,
    input  logic        [dtd_pkg::RADIUS_W-1:0] i_radius,
    output logic                                o_within
);
    import dtd_pkg::*;

    localparam int DW   = COORD_BITS + 1;
    localparam int SQW  = 2 * DW;
    localparam int CMPW = (SQW > 2 * RADIUS_W) ? SQW : 2 * RADIUS_W;

    logic signed [DW-1:0]         dx;
    logic signed [DW-1:0]         dy;
    logic signed [SQW-1:0]        sq_x;
    logic signed [SQW-1:0]        sq_y;
    logic        [CMPW-1:0]       dist2;
    logic        [2*RADIUS_W-1:0] rad2;

    assign dx    = $signed({i_a_x[COORD_BITS-1], i_a_x}) - $signed({i_b_x[COORD_BITS-1], i_b_x});
    assign dy    = $signed({i_a_y[COORD_BITS-1], i_a_y}) - $signed({i_b_y[COORD_BITS-1], i_b_y});
    assign sq_x  = dx * dx;
    assign sq_y  = dy * dy;
    assign dist2 = CMPW'($unsigned(sq_x)) + CMPW'($unsigned(sq_y));
    assign rad2  = i_radius * i_radius;
    assign o_within = dist2 <= CMPW'(rad2);

endmodule

[rtl/double_tap_detector_top.sv]
// double tap detector top level: input register, tap tracker and result register
// depends on dtd_pkg and dtd_within
//
// usage:
//   s_axis carries pointer events, one transfer per event; m_axis returns one
//   result per event, in order. tuser in holds the pointer flags, tdata in the
//   position and timestamp. tuser out holds outcome and the pending flag, tdata
//   out the position of the most recent double tap.
//   from the input transfer to o_m_axis_tvalid an event passes the input
//   register, then goes through the tracker into the result register.
//   throughput is one event per cycle without stalls; the tracker state is read
//   and written in the same cycle, so back-to-back events see each other's updates.
//   when the receiver stalls, the result register holds and the input register
//   fills; o_s_axis_tready drops only when both are full.
//   the config port writes one register per cycle with i_cfg_we; write only
//   while no event is in flight.
//   i_rst_n (synchronous, active low) empties both stages, clears the tracker
//   state and loads the register reset values.
module double_tap_detector_top #(
    parameter int COORD_BITS = dtd_pkg::COORD_BITS_DEF,
    parameter int TIME_BITS  = dtd_pkg::TIME_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // in tdata: x_position, y_position, time_ms, zero fill
    input  logic [((2*COORD_BITS+TIME_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // in tuser: pointer_down, pointer_moved
    input  logic [1:0]                             i_s_axis_tuser,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // out tdata: tap_x, tap_y, zero fill
    output logic [((2*COORD_BITS+7)/8)*8-1:0]      o_m_axis_tdata,
    // out tuser: outcome, first_tap_pending
    output logic [3:0]                             o_m_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    input  logic                                   i_cfg_we,
    input  logic [dtd_pkg::CFG_ADDR_W-1:0]         i_cfg_addr,
    input  logic [dtd_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import dtd_pkg::*;

    localparam int IN_W  = ((2*COORD_BITS+TIME_BITS+7)/8)*8;
    localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;

    // config registers
    logic                r_enable;
    logic [RADIUS_W-1:0] r_tap_radius;
    logic [LIMIT_W-1:0]  r_tap_max_dur;
    logic [LIMIT_W-1:0]  r_double_intvl;
    logic [RADIUS_W-1:0] r_second_radius;

    // input register
    logic            r_in_valid;
    logic [IN_W-1:0] r_in_data;
    logic [1:0]      r_in_user;

    // tracker state
    logic                         r_tracking, n_tracking;
    logic signed [COORD_BITS-1:0] r_press_x, n_press_x;
    logic signed [COORD_BITS-1:0] r_press_y, n_press_y;
    logic [TIME_BITS-1:0]         r_press_t, n_press_t;
    logic                         r_pending, n_pending;
    logic [TIME_BITS-1:0]         r_first_t, n_first_t;
    logic signed [COORD_BITS-1:0] r_first_x, n_first_x;
    logic signed [COORD_BITS-1:0] r_first_y, n_first_y;
    logic signed [COORD_BITS-1:0] r_held_x, n_held_x;
    logic signed [COORD_BITS-1:0] r_held_y, n_held_y;

    // result register
    logic     r_out_valid;
    t_outcome r_out_outcome, n_outcome;

    logic                         w_out_ready;
    logic                         w_step;
    logic                         w_down;
    logic                         w_moved;
    logic signed [COORD_BITS-1:0] w_x;
    logic signed [COORD_BITS-1:0] w_y;
    logic [TIME_BITS-1:0]         w_t;
    logic [TIME_BITS-1:0]         w_dur;
    logic [TIME_BITS-1:0]         w_gap;
    logic                         w_near_press;
    logic                         w_near_first;
    t_tap                         w_tap;

    assign w_out_ready     = !r_out_valid || i_m_axis_tready;
    assign w_step          = r_in_valid && w_out_ready;
    assign o_s_axis_tready = !r_in_valid || w_out_ready;

    assign w_down  = r_in_user[0];
    assign w_moved = r_in_user[1];
    assign w_x     = r_in_data[COORD_BITS-1:0];
    assign w_y     = r_in_data[2*COORD_BITS-1:COORD_BITS];
    assign w_t     = r_in_data[2*COORD_BITS+TIME_BITS-1:2*COORD_BITS];
    assign w_dur   = w_t - r_press_t;
    assign w_gap   = w_t - r_first_t;

    dtd_within #(.COORD_BITS(COORD_BITS)) u_near_press (
        .i_a_x    (w_x),
        .i_a_y    (w_y),
        .i_b_x    (r_press_x),
        .i_b_y    (r_press_y),
        .i_radius (r_tap_radius),
        .o_within (w_near_press)
    );

    dtd_within #(.COORD_BITS(COORD_BITS)) u_near_first (
        .i_a_x    (w_x),
        .i_a_y    (w_y),
        .i_b_x    (r_first_x),
        .i_b_y    (r_first_y),
        .i_radius (r_second_radius),
        .o_within (w_near_first)
    );

    always_comb begin
        n_tracking = r_tracking;
        n_press_x  = r_press_x;
        n_press_y  = r_press_y;
        n_press_t  = r_press_t;
        n_pending  = r_pending;
        n_first_t  = r_first_t;
        n_first_x  = r_first_x;
        n_first_y  = r_first_y;
        n_held_x   = r_held_x;
        n_held_y   = r_held_y;
        n_outcome  = OUT_NONE;
        w_tap      = TAP_NONE;
        if (r_enable) begin
            priority if (w_down && !r_tracking) begin
                n_press_x  = w_x;
                n_press_y  = w_y;
                n_press_t  = w_t;
                n_tracking = 1'b1;
            end else if (r_tracking && w_moved) begin
                if (!w_near_press) begin
                    n_tracking = 1'b0;
                    w_tap      = TAP_FAIL;
                end
            end else if (r_tracking && !w_down) begin
                n_tracking = 1'b0;
                if (w_dur <= TIME_BITS'(r_tap_max_dur) && w_near_press) begin
                    w_tap = TAP_OK;
                end else begin
                    w_tap = TAP_FAIL;
                end
            end else begin
            end

            unique case (w_tap)
                TAP_OK: begin
                    if (!r_pending) begin
                        n_pending = 1'b1;
                        n_first_t = w_t;
                        n_first_x = w_x;
                        n_first_y = w_y;
                        n_outcome = OUT_FIRST;
                    end else begin
                        if (w_gap <= TIME_BITS'(r_double_intvl) && w_near_first) begin
                            n_held_x  = w_x;
                            n_held_y  = w_y;
                            n_outcome = OUT_DOUBLE;
                        end else begin
                            n_outcome = OUT_REJECT;
                        end
                        n_pending = 1'b0;
                    end
                end
                TAP_FAIL: begin
                    n_pending = 1'b0;
                    n_outcome = OUT_FAILED;
                end
                default: begin
                end
            endcase

            // pending first tap times out; a fresh first tap has age zero
            if (n_pending && n_outcome != OUT_FIRST &&
                w_gap > TIME_BITS'(r_double_intvl)) begin
                n_pending = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable        <= 1'b1;
            r_tap_radius    <= TAP_RADIUS_RST;
            r_tap_max_dur   <= TAP_MAX_DUR_RST;
            r_double_intvl  <= DOUBLE_INTVL_RST;
            r_second_radius <= SECOND_RADIUS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_ENABLE:        r_enable        <= i_cfg_data[0];
                REG_TAP_RADIUS:    r_tap_radius    <= i_cfg_data[RADIUS_W-1:0];
                REG_TAP_MAX_DUR:   r_tap_max_dur   <= i_cfg_data[LIMIT_W-1:0];
                REG_DOUBLE_INTVL:  r_double_intvl  <= i_cfg_data[LIMIT_W-1:0];
                REG_SECOND_RADIUS: r_second_radius <= i_cfg_data[RADIUS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_data <= i_s_axis_tdata;
            r_in_user <= i_s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracking <= 1'b0;
            r_press_x  <= '0;
            r_press_y  <= '0;
            r_press_t  <= '0;
            r_pending  <= 1'b0;
            r_first_t  <= '0;
            r_first_x  <= '0;
            r_first_y  <= '0;
            r_held_x   <= '0;
            r_held_y   <= '0;
        end else if (w_step) begin
            r_tracking <= n_tracking;
            r_press_x  <= n_press_x;
            r_press_y  <= n_press_y;
            r_press_t  <= n_press_t;
            r_pending  <= n_pending;
            r_first_t  <= n_first_t;
            r_first_x  <= n_first_x;
            r_first_y  <= n_first_y;
            r_held_x   <= n_held_x;
            r_held_y   <= n_held_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_outcome <= n_outcome;
        end
    end

    // held position and pending flag only change on a step, so they read from state
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = {r_pending, r_out_outcome};
    assign o_m_axis_tdata  = OUT_W'({r_held_y, r_held_x});

    // a first tap always leaves one pending
    a_first_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_outcome == OUT_FIRST |-> r_pending)
        else $error("first tap result without pending first tap");

    // a double, rejected or failed tap leaves nothing pending
    a_closed_not_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_outcome == OUT_DOUBLE || r_out_outcome == OUT_REJECT ||
        r_out_outcome == OUT_FAILED) |-> !r_pending)
        else $error("pending first tap survived a closing outcome");

    // held position moves only on a double tap
    a_held_on_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && n_outcome != OUT_DOUBLE |=> $stable(r_held_x) && $stable(r_held_y))
        else $error("held position changed without a double tap");

    // disabled detector leaves tracker state alone
    a_disabled_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && !r_enable |=> $stable(r_tracking) && $stable(r_pending))
        else $error("tracker state changed while disabled");

    // a stalled result keeps the event in the input stage
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_out_ready |=> r_in_valid && r_out_valid)
        else $error("event lost while result stalled");

endmodule

[test/tb_top.sv]
// testbench for double_tap_detector_top: stream driver, scoreboard and event predictor
// depends on dtd_pkg and the double tap detector rtl
module tb_top;
    import dtd_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    typedef struct {
        t_outcome    outcome;
        logic        pending;
        logic [15:0] tap_x;
        logic [15:0] tap_y;
    } t_tap_result;

    class double_tap_scoreboard;
        logic        enable        = 1'b1;
        logic [11:0] tap_radius    = TAP_RADIUS_RST;
        logic [15:0] max_duration  = TAP_MAX_DUR_RST;
        logic [15:0] interval      = DOUBLE_INTVL_RST;
        logic [11:0] second_radius = SECOND_RADIUS_RST;

        logic        tracking   = 1'b0;
        logic [15:0] start_x    = '0;
        logic [15:0] start_y    = '0;
        logic [31:0] start_time = '0;
        logic        pending    = 1'b0;
        logic [31:0] first_time = '0;
        logic [15:0] first_x    = '0;
        logic [15:0] first_y    = '0;
        logic [15:0] held_x     = '0;
        logic [15:0] held_y     = '0;

        t_tap_result expected[$];
        int          mismatches = 0;
        int          results    = 0;

        function void write_reg(t_cfg_reg idx, logic [15:0] val);
            case (idx)
                REG_ENABLE:        enable        = val[0];
                REG_TAP_RADIUS:    tap_radius    = val[11:0];
                REG_TAP_MAX_DUR:   max_duration  = val;
                REG_DOUBLE_INTVL:  interval      = val;
                REG_SECOND_RADIUS: second_radius = val[11:0];
                default: ;
            endcase
        endfunction

        function bit near(logic signed [15:0] ax, logic signed [15:0] ay,
                          logic signed [15:0] bx, logic signed [15:0] by,
                          logic [11:0] rad);
            longint dx;
            longint dy;
            longint lim;
            dx  = longint'(ax) - longint'(bx);
            dy  = longint'(ay) - longint'(by);
            lim = longint'(rad) * longint'(rad);
            return dx * dx + dy * dy <= lim;
        endfunction

        function void note_event(bit down, bit moved, logic [15:0] x, logic [15:0] y,
                                 logic [31:0] t);
            t_tap_result r;
            t_tap        tap;
            logic [31:0] span;
            tap = TAP_NONE;
            r.outcome = OUT_NONE;
            if (enable) begin
                if (down && !tracking) begin
                    start_x    = x;
                    start_y    = y;
                    start_time = t;
                    tracking   = 1'b1;
                end else if (tracking && moved) begin
                    if (!near(x, y, start_x, start_y, tap_radius)) begin
                        tracking = 1'b0;
                        tap = TAP_FAIL;
                    end
                end else if (tracking && !down) begin
                    span = t - start_time;
                    tracking = 1'b0;
                    if (span <= {16'd0, max_duration} && near(x, y, start_x, start_y, tap_radius))
                        tap = TAP_OK;
                    else
                        tap = TAP_FAIL;
                end

                if (tap == TAP_OK) begin
                    if (!pending) begin
                        pending    = 1'b1;
                        first_time = t;
                        first_x    = x;
                        first_y    = y;
                        r.outcome  = OUT_FIRST;
                    end else begin
                        span = t - first_time;
                        if (span <= {16'd0, interval} &&
                            near(x, y, first_x, first_y, second_radius)) begin
                            held_x = x;
                            held_y = y;
                            r.outcome = OUT_DOUBLE;
                        end else begin
                            r.outcome = OUT_REJECT;
                        end
                        pending = 1'b0;
                    end
                end else if (tap == TAP_FAIL) begin
                    pending = 1'b0;
                    r.outcome = OUT_FAILED;
                end

                // silent timeout of a waiting first tap
                span = t - first_time;
                if (pending && span > {16'd0, interval})
                    pending = 1'b0;
            end
            r.pending = pending;
            r.tap_x   = held_x;
            r.tap_y   = held_y;
            expected.push_back(r);
        endfunction

        task flag(string field, longint got, longint want);
            mismatches++;
            $display("result %0d: %s is %0h, expected %0h", results, field, got, want);
        endtask

        task check_result(logic [3:0] user, logic [31:0] data);
            t_tap_result want;
            results++;
            if (expected.size() == 0) begin
                flag("transfer with nothing expected, tdata", data, 0);
            end else begin
                want = expected.pop_front();
                if (user[2:0] !== want.outcome)
                    flag("outcome", user[2:0], want.outcome);
                if (user[3] !== want.pending)
                    flag("first_tap_pending", user[3], want.pending);
                if (data[15:0] !== want.tap_x)
                    flag("tap_x", data[15:0], want.tap_x);
                if (data[31:16] !== want.tap_y)
                    flag("tap_y", data[31:16], want.tap_y);
            end
        endtask

        function int outstanding();
            return expected.size();
        endfunction
    endclass

    logic                  i_clk    = 1'b0;
    logic                  rst_n    = 1'b0;
    // tdata: x_position, y_position, time_ms
    logic [63:0]           s_data   = '0;
    // tuser: pointer_down, pointer_moved
    logic [1:0]            s_user   = '0;
    logic                  s_valid  = 1'b0;
    logic                  o_s_axis_tready;
    // tdata: tap_x, tap_y
    logic [31:0]           o_m_axis_tdata;
    // tuser: outcome, first_tap_pending
    logic [3:0]            o_m_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  m_ready  = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    double_tap_scoreboard sb = new;
    logic [31:0] now        = '0;
    int          sent       = 0;
    int          quiet      = 0;
    int          stall_left = 0;
    bit          send_idle  = 1'b1;
    bit          recv_idle  = 1'b1;

    double_tap_detector_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // result side: check each transfer, stall in random bursts while recv_idle is set
    always @(posedge i_clk) begin
        if (rst_n && o_m_axis_tvalid && m_ready)
            sb.check_result(o_m_axis_tuser, o_m_axis_tdata);
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (recv_idle && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 9);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready) || cfg_we || !rst_n) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic int jit(int s);
        return int'($urandom_range(0, 2 * s)) - s;
    endfunction

    task automatic drive_event(bit down, bit moved, int x, int y, logic [31:0] t);
        logic [15:0] xs;
        logic [15:0] ys;
        xs = x[15:0];
        ys = y[15:0];
        if (send_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {t, ys, xs};
        s_user  <= {moved, down};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_event(down, moved, xs, ys, t);
        sent++;
    endtask

    task automatic load_settings(bit en, int tr, int md, int di, int sr);
        logic [15:0] vals [5];
        t_cfg_reg    idx;
        vals = '{{15'd0, en}, tr[15:0], md[15:0], di[15:0], sr[15:0]};
        idx = REG_ENABLE;
        for (int k = 0; k < 5; k++) begin
            cfg_we   <= 1'b1;
            cfg_addr <= idx;
            cfg_data <= vals[k];
            @(posedge i_clk);
            sb.write_reg(idx, vals[k]);
            idx = idx.next();
        end
        cfg_we <= 1'b0;
    endtask

    // press, a few motion or press events, then release after dur
    task automatic do_tap(int x, int y, int dur, int moves, int spread);
        logic [31:0] t0;
        int          kind;
        t0 = now;
        drive_event(1'b1, 1'b0, x, y, t0);
        for (int k = 1; k <= moves; k++) begin
            kind = $urandom_range(0, 2);
            now = t0 + dur * k / (moves + 1);
            drive_event(kind != 1, kind != 2, x + jit(spread), y + jit(spread), now);
        end
        now = t0 + dur;
        drive_event(1'b0, 1'b0, x + jit(spread), y + jit(spread), now);
    endtask

    task automatic random_gesture();
        int pick;
        int rad;
        int sr;
        int md;
        int di;
        int spread;
        int gap;
        int d2;
        int fx;
        int fy;
        logic [31:0] t;
        pick = $urandom_range(0, 19);
        rad  = sb.tap_radius;
        sr   = sb.second_radius;
        md   = sb.max_duration;
        di   = sb.interval;
        fx   = int'($urandom_range(0, 65535)) - 32768;
        fy   = int'($urandom_range(0, 65535)) - 32768;
        if (pick < 14) begin
            spread = ($urandom_range(0, 3) == 0) ? rad + 2 : rad * 7 / 10;
            do_tap(fx, fy, $urandom_range(0, md + md / 8 + 2), $urandom_range(0, 2), spread);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(0, di + di / 8 + 2);
                d2  = $urandom_range(0, (gap < md) ? gap : md);
                now = now + gap - d2;
                do_tap(fx + jit(sr * 3 / 4 + 1), fy + jit(sr * 3 / 4 + 1), d2,
                       $urandom_range(0, 1), rad / 2);
            end
            now = now + $urandom_range(1, di + 50);
        end else if (pick < 16) begin
            // press that wanders out of the tap radius
            drive_event(1'b1, 1'b0, fx, fy, now);
            now = now + $urandom_range(1, 50);
            drive_event(1'($urandom_range(0, 1)), 1'b1, fx + rad + 1 + $urandom_range(0, 20),
                        fy, now);
            now = now + $urandom_range(1, 100);
        end else if (pick < 19) begin
            t = $urandom;
            drive_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        $urandom_range(0, 65535), $urandom_range(0, 65535), t);
            if ($urandom_range(0, 1) == 0)
                now = t;
        end else begin
            now = 32'hFFFF_FFFF - $urandom_range(0, 400);
        end
    endtask

    task automatic run_phase(bit en, int tr, int md, int di, int sr, int n, bit idle);
        int stop;
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        load_settings(en, tr, md, di, sr);
        send_idle = idle;
        recv_idle = idle;
        stop = sent + n;
        while (sent < stop) random_gesture();
    endtask

    // default settings: radius 10, duration 300, interval 300, second radius 20
    task automatic directed_checks();
        drive_event(1'b0, 1'b0, 5, 5, 1000);           // release while idle
        drive_event(1'b1, 1'b0, 100, 100, 1000);
        drive_event(1'b1, 1'b0, 120, 120, 1010);       // press while tracking
        drive_event(1'b1, 1'b1, 106, 108, 1100);       // motion right on the radius
        drive_event(1'b0, 1'b0, 103, 104, 1300);       // longest tap, first tap
        drive_event(1'b1, 1'b0, 105, 110, 1400);
        drive_event(1'b0, 1'b0, 105, 110, 1600);       // double tap at the interval
        drive_event(1'b1, 1'b0, -32768, 32767, 2000);
        drive_event(1'b0, 1'b1, -32768, 32756, 2050);  // motion without press, too far
        drive_event(1'b1, 1'b0, 32767, -32768, 2100);
        drive_event(1'b0, 1'b0, 32767, -32768, 2401);  // press too long
        drive_event(1'b1, 1'b0, 0, 0, 3000);
        drive_event(1'b0, 1'b0, 0, 0, 3010);
        drive_event(1'b0, 1'b0, 0, 0, 3311);           // first tap times out
        drive_event(1'b1, 1'b0, 0, 0, 4000);
        drive_event(1'b0, 1'b0, 0, 0, 4005);
        drive_event(1'b1, 1'b0, 21, 0, 4100);
        drive_event(1'b0, 1'b0, 21, 0, 4110);          // second tap too far
        drive_event(1'b1, 1'b0, 7, 7, 5000);
        drive_event(1'b0, 1'b0, 7, 7, 5010);
        drive_event(1'b1, 1'b0, 7, 7, 5200);
        drive_event(1'b0, 1'b0, 7, 7, 5311);           // second tap too late
        drive_event(1'b1, 1'b0, 50, 50, 32'hFFFF_FF00);
        drive_event(1'b0, 1'b0, 50, 50, 32'h0000_0010); // tap across time wrap
        drive_event(1'b1, 1'b0, 50, 50, 32'h0000_0020);
        drive_event(1'b0, 1'b0, 61, 50, 32'h0000_0030); // release out of radius
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        directed_checks();
        run_phase(1'b1, 10, 300, 300, 20, 110, 1'b1);
        run_phase(1'b1, 0, 0, 0, 0, 90, 1'b1);
        run_phase(1'b1, 4095, 65535, 65535, 4095, 90, 1'b1);
        run_phase(1'b0, $urandom_range(0, 4095), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 4095), 25, 1'b1);
        run_phase(1'b1, $urandom_range(1, 60), $urandom_range(20, 1000),
                  $urandom_range(20, 1000), $urandom_range(1, 80), 110, 1'b1);
        run_phase(1'b1, 3, 50, 80, 6, 100, 1'b1);
        run_phase(1'b1, $urandom_range(0, 4095), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 4095), 110, 1'b1);
        run_phase(1'b1, 10, 300, 300, 20, 100, 1'b0);
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule

[files.f]
rtl/dtd_pkg.sv
rtl/dtd_within.sv
rtl/double_tap_detector_top.sv
test/tb_top.sv
